@@ hdl/aes128_key_expansion_macros.svh @@
// ---------------------------------------------------------------------------
// AES-128 key expansion assertion macros
// Immediate-consequence and next-cycle checks, clocked on clock and
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef AES128_KEY_EXPANSION_MACROS_SVH
`define AES128_KEY_EXPANSION_MACROS_SVH

`ifndef ASSERT_OFF
`define AESK_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aes128_key_expansion: assertion failed");
`define AESK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aes128_key_expansion: assertion failed");
`else
`define AESK_ASSERT_IMPL(label, ante, cons)
`define AESK_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/aesk_pkg.sv @@
// ---------------------------------------------------------------------------
// AES-128 key expansion package
// Types, S-box table and round-constant helpers shared by the key schedule.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aesk_pkg;

   localparam int unsigned KEY_WIDTH   = 128;
   localparam int unsigned HALF_WIDTH  = 64;
   localparam int unsigned ROUND_WIDTH = 4;
   localparam int unsigned RSP_WIDTH   = 136;
   localparam int unsigned RSP_PAD     = RSP_WIDTH - ROUND_WIDTH - KEY_WIDTH;

   localparam logic [ROUND_WIDTH-1:0] LAST_ROUND = 4'd10;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic load_key;
      logic emit;
   } aesk_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_round;
   } aesk_stat_type;

   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic logic [31:0] sub_word(input logic [31:0] value);
      sub_word = {SBOX_TABLE[value[31:24]], SBOX_TABLE[value[23:16]],
                  SBOX_TABLE[value[15:8]],  SBOX_TABLE[value[7:0]]};
   endfunction

   function automatic logic [7:0] round_const(input logic [ROUND_WIDTH-1:0] round);
      case (round)
         4'd1:    round_const = 8'h01;
         4'd2:    round_const = 8'h02;
         4'd3:    round_const = 8'h04;
         4'd4:    round_const = 8'h08;
         4'd5:    round_const = 8'h10;
         4'd6:    round_const = 8'h20;
         4'd7:    round_const = 8'h40;
         4'd8:    round_const = 8'h80;
         4'd9:    round_const = 8'h1b;
         4'd10:   round_const = 8'h36;
         default: round_const = 8'h00;
      endcase
   endfunction

endpackage

`default_nettype wire

@@ hdl/aes128_key_expansion.sv @@
// ---------------------------------------------------------------------------
// AES-128 key expansion
// Expands one 128-bit cipher key into the eleven AES-128 round keys.
//
// Usage:
//   req channel carries one cipher key per item. rsp channel returns the
//   round keys 0 to 10 in order, one item each, tlast set on round 10.
//   A key taken on req is loaded into the working register; round key 0 then
//   moves from it into the output register to be presented, and each later
//   round key is presented in the cycle after the previous one is taken.
//   One round-key generator (rotate, S-box, round constant, word XOR chain)
//   makes one round key per cycle while rsp does not stall, and the next key
//   is taken in the same cycle as round 10 leaves the generator.
//   A stall on rsp holds the output register and the generator; req_tready
//   stays low until round 10 is emitted.
//   Reset (synchronous, active high) drops any key in progress and clears
//   the output valid; no state survives from one key to the next.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "aes128_key_expansion_macros.svh"

module aes128_key_expansion (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [63:0] key_high, [127:64] key_low
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [3:0] round_number, [67:4] round_key_high, [131:68] round_key_low,
   // [135:132] zero
   output logic [135:0]      rsp_tdata,
   output logic              rsp_tlast
);
   import aesk_pkg::*;

   aesk_cmd_type           cmd;
   aesk_stat_type          stat;
   ctrl_state_type         state;
   logic [ROUND_WIDTH-1:0] rsp_round;
   logic [KEY_WIDTH-1:0]   rsp_key;

   aesk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd),
      .state      (state)
   );

   aesk_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .key_in     ({req_tdata[63:0], req_tdata[127:64]}),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_round  (rsp_round),
      .rsp_key    (rsp_key),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, rsp_key[63:0], rsp_key[127:64], rsp_round};

   `AESK_ASSERT_IMPL(a_accept_only_when_free, req_tvalid && req_tready, (state == ST_IDLE) || (cmd.emit && stat.last_round))
   `AESK_ASSERT_NEXT(a_emit_gives_valid, cmd.emit, rsp_tvalid)
   `AESK_ASSERT_IMPL(a_last_is_round_ten, rsp_tvalid && rsp_tlast, rsp_tdata[3:0] == LAST_ROUND)
   `AESK_ASSERT_IMPL(a_idle_no_emit, state == ST_IDLE, !cmd.emit)

endmodule

`default_nettype wire

@@ hdl/aesk_ctrl.sv @@
// ---------------------------------------------------------------------------
// AES-128 key expansion controller
// Sequences one key through eleven round-key emissions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aesk_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire aesk_pkg::aesk_stat_type stat,
   output aesk_pkg::aesk_cmd_type      cmd,
   output aesk_pkg::ctrl_state_type    state
);
   import aesk_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           emit_last;

   assign emit_last = (state_ff == ST_RUN) && stat.out_free && stat.last_round;
   assign state     = state_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (emit_last && !req_tvalid) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd.load_key = 1'b0;
      cmd.emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_key = req_tvalid;
         end
         ST_RUN: begin
            cmd.emit     = stat.out_free;
            req_tready   = emit_last;
            cmd.load_key = emit_last && req_tvalid;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/aesk_datapath.sv @@
// ---------------------------------------------------------------------------
// AES-128 key expansion datapath
// Working round-key register, round counter, next-round logic and output
// register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aesk_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire aesk_pkg::aesk_cmd_type                  cmd,
   output aesk_pkg::aesk_stat_type                      stat,
   input  wire logic [aesk_pkg::KEY_WIDTH-1:0]          key_in,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   output logic [aesk_pkg::ROUND_WIDTH-1:0]             rsp_round,
   output logic [aesk_pkg::KEY_WIDTH-1:0]               rsp_key,
   output logic                                         rsp_last
);
   import aesk_pkg::*;

   logic [KEY_WIDTH-1:0]   work_ff;
   logic [KEY_WIDTH-1:0]   work_in;
   logic [ROUND_WIDTH-1:0] round_ff;
   logic [ROUND_WIDTH-1:0] round_in;
   logic [ROUND_WIDTH-1:0] round_next;
   logic                   valid_ff;
   logic                   valid_in;
   logic [ROUND_WIDTH-1:0] out_round_ff;
   logic [KEY_WIDTH-1:0]   out_key_ff;
   logic [31:0]            temp_word;
   logic [31:0]            w0_next;
   logic [31:0]            w1_next;
   logic [31:0]            w2_next;
   logic [31:0]            w3_next;

   assign round_next = round_ff + 4'd1;

   assign temp_word = sub_word({work_ff[23:0], work_ff[31:24]})
                      ^ {round_const(round_next), 24'h000000};
   assign w0_next   = work_ff[127:96] ^ temp_word;
   assign w1_next   = work_ff[95:64] ^ w0_next;
   assign w2_next   = work_ff[63:32] ^ w1_next;
   assign w3_next   = work_ff[31:0] ^ w2_next;

   assign stat.out_free   = !valid_ff || rsp_tready;
   assign stat.last_round = (round_ff == LAST_ROUND);

   always_comb begin
      work_in  = work_ff;
      round_in = round_ff;
      if (cmd.load_key) begin
         work_in  = key_in;
         round_in = '0;
      end else if (cmd.emit) begin
         work_in  = {w0_next, w1_next, w2_next, w3_next};
         round_in = round_next;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         round_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (cmd.emit) begin
         out_round_ff <= round_ff;
         out_key_ff   <= work_ff;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_round  = out_round_ff;
   assign rsp_key    = out_key_ff;
   assign rsp_last   = (out_round_ff == LAST_ROUND);

endmodule

`default_nettype wire

@@ dv/aes128_key_expansion_tb.sv @@
// ---------------------------------------------------------------------------
// AES-128 key expansion testbench
// Sends cipher keys on the req stream and checks every round key on the rsp
// stream against a key-schedule predictor built on a computed S-box. Known
// FIPS-197 final round keys are checked directly. Traffic runs in three
// modes: gappy sender with heavy back-pressure, the reverse, and free
// running with one long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes128_key_expansion_tb;

   localparam int LAST_ROUND_IDX = 10;
   localparam int RANDOM_KEYS    = 160;
   localparam int LONG_HOLD      = 300;

   typedef enum logic [1:0] {
      MODE_SEND_GAPS,
      MODE_RECV_GAPS,
      MODE_FREE_RUN
   } traffic_mode_type;

   typedef struct packed {
      logic [3:0]  round;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic        last;
   } round_key_type;

   typedef struct packed {
      logic [63:0]  key_hi;
      logic [63:0]  key_lo;
      logic         known;
      logic [127:0] final_key;
   } key_row_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         rsp_tlast;

   traffic_mode_type traffic_mode = MODE_SEND_GAPS;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               fail_count    = 0;
   int               keys_sent     = 0;
   int               round_keys_checked = 0;
   logic [7:0]       sbox_lut [256];
   round_key_type    expected_keys [$];

   key_row_type directed_keys [10] = '{
      '{64'h0000000000000000, 64'h0000000000000000, 1'b1,
        128'hb4ef5bcb3e92e21123e951cf6f8f188e},
      '{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 128'h0},
      '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1,
        128'hd014f9a8c9ee2589e13f0cc8b6630ca6},
      '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1,
        128'h13111d7fe3944a17f307a78b4d2b30c5},
      '{64'h0000000000000000, 64'hffffffffffffffff, 1'b0, 128'h0},
      '{64'hffffffffffffffff, 64'h0000000000000000, 1'b0, 128'h0},
      '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 128'h0},
      '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 128'h0},
      '{64'h8000000000000000, 64'h0000000000000001, 1'b0, 128'h0},
      '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 128'h0}
   };

   aes128_key_expansion u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x   = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= x;
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   // multiplicative inverse as a^254, then the affine map
   function automatic logic [7:0] sbox_byte(input logic [7:0] a);
      logic [7:0] p;
      logic [7:0] inv;
      p   = a;
      inv = 8'h01;
      for (int i = 1; i < 8; i++) begin
         p   = gf_mul(p, p);
         inv = gf_mul(inv, p);
      end
      return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
   endfunction

   function automatic void queue_round_keys(input logic [63:0] key_hi,
                                            input logic [63:0] key_lo,
                                            input logic known,
                                            input logic [127:0] final_key);
      logic [31:0]   w [4];
      logic [31:0]   t;
      logic [7:0]    rc;
      round_key_type rk;
      w[0] = key_hi[63:32];
      w[1] = key_hi[31:0];
      w[2] = key_lo[63:32];
      w[3] = key_lo[31:0];
      rc   = 8'h01;
      for (int r = 0; r <= LAST_ROUND_IDX; r++) begin
         if (r > 0) begin
            t = {sbox_lut[w[3][23:16]], sbox_lut[w[3][15:8]],
                 sbox_lut[w[3][7:0]], sbox_lut[w[3][31:24]]};
            t[31:24] ^= rc;
            rc = gf_mul(rc, 8'h02);
            w[0] ^= t;
            w[1] ^= w[0];
            w[2] ^= w[1];
            w[3] ^= w[2];
         end
         rk.round  = 4'(r);
         rk.key_hi = {w[0], w[1]};
         rk.key_lo = {w[2], w[3]};
         rk.last   = (r == LAST_ROUND_IDX);
         if (known && r == LAST_ROUND_IDX) {rk.key_hi, rk.key_lo} = final_key;
         expected_keys.insert(expected_keys.size(), rk);
      end
   endfunction

   task automatic set_mode(input traffic_mode_type mode);
      traffic_mode = mode;
      case (mode)
         MODE_SEND_GAPS: begin
            send_idle_pct = 24;
            recv_idle_pct = 49;
         end
         MODE_RECV_GAPS: begin
            send_idle_pct = 49;
            recv_idle_pct = 24;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic drive_key(input logic [63:0] key_hi, input logic [63:0] key_lo,
                            input logic known, input logic [127:0] final_key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {key_lo, key_hi};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      queue_round_keys(key_hi, key_lo, known, final_key);
      keys_sent++;
   endtask

   // receiver: random back-pressure, plus one long hold once free running
   initial begin : rsp_ready_drive
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && !reset && traffic_mode == MODE_FREE_RUN) begin
            held      = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      round_key_type exp_rk;
      round_key_type got_rk;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rk = {rsp_tdata[3:0], rsp_tdata[67:4], rsp_tdata[131:68], rsp_tlast};
         if (expected_keys.size() == 0) begin
            $display("%0t unexpected round key item: round %0d %h_%h", $time,
                     got_rk.round, got_rk.key_hi, got_rk.key_lo);
            fail_count++;
         end else begin
            exp_rk = expected_keys.pop_front();
            round_keys_checked++;
            if (got_rk.round !== exp_rk.round) begin
               $display("%0t round_number mismatch: expected %0d, actual %0d", $time,
                        exp_rk.round, got_rk.round);
               fail_count++;
            end
            if (got_rk.key_hi !== exp_rk.key_hi) begin
               $display("%0t round %0d round_key_high mismatch: expected %h, actual %h",
                        $time, exp_rk.round, exp_rk.key_hi, got_rk.key_hi);
               fail_count++;
            end
            if (got_rk.key_lo !== exp_rk.key_lo) begin
               $display("%0t round %0d round_key_low mismatch: expected %h, actual %h",
                        $time, exp_rk.round, exp_rk.key_lo, got_rk.key_lo);
               fail_count++;
            end
            if (got_rk.last !== exp_rk.last) begin
               $display("%0t round %0d tlast mismatch: expected %b, actual %b",
                        $time, exp_rk.round, exp_rk.last, got_rk.last);
               fail_count++;
            end
            if (rsp_tdata[135:132] !== 4'h0) begin
               $display("%0t round %0d pad bits mismatch: expected 0, actual %h",
                        $time, exp_rk.round, rsp_tdata[135:132]);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [7:0]  fill;
      for (int i = 0; i < 256; i++) sbox_lut[i] = sbox_byte(8'(i));
      set_mode(MODE_SEND_GAPS);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_keys[i])
         drive_key(directed_keys[i].key_hi, directed_keys[i].key_lo,
                   directed_keys[i].known, directed_keys[i].final_key);

      for (int n = 0; n < RANDOM_KEYS; n++) begin
         if (n == RANDOM_KEYS / 3) set_mode(MODE_RECV_GAPS);
         if (n == 2 * RANDOM_KEYS / 3) set_mode(MODE_FREE_RUN);
         case ($urandom_range(7))
            0: begin
               fill   = 8'($urandom_range(255));
               key_hi = {8{fill}};
               key_lo = {8{fill}};
            end
            1: begin
               key_hi = 64'h1 << $urandom_range(63);
               key_lo = ~(64'h1 << $urandom_range(63));
            end
            default: begin
               key_hi = {$urandom, $urandom};
               key_lo = {$urandom, $urandom};
            end
         endcase
         drive_key(key_hi, key_lo, 1'b0, 128'h0);
      end
      req_tvalid <= 1'b0;

      while (expected_keys.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      $display("Covered %0d cipher keys, %0d round keys checked, across three traffic modes",
               keys_sent, round_keys_checked);
      $display("including a %0d-cycle output hold with the input left pending.", LONG_HOLD);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_400_000;
      $display("Timeout with %0d round keys outstanding", expected_keys.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
